>>> sv/gmcp_pkg.sv
package gmcp_pkg;

  localparam int COST_WIDTH     = 16;
  localparam int SUM_WIDTH      = 32;
  localparam int NUM_COLS_WIDTH = 11;
  localparam int MAX_COLS_DEF   = 1024;

  typedef struct packed {
    logic signed [COST_WIDTH-1:0] cell_cost;
    logic                         last_cell;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_WIDTH-1:0] path_cost;
    logic                        saturated;
  } out_item_t;

  // Position of the cell in the grid, as seen by the adder stage.
  typedef struct packed {
    logic first_row;
    logic first_col;
  } cell_pos_t;

endpackage

>>> sv/gmcp_ram.sv
module gmcp_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/gmcp_addsat.sv
module gmcp_addsat (
  input  logic signed [gmcp_pkg::COST_WIDTH-1:0] cost_i,
  input  logic signed [gmcp_pkg::SUM_WIDTH-1:0]  up_i,
  input  logic signed [gmcp_pkg::SUM_WIDTH-1:0]  left_i,
  input  logic signed [gmcp_pkg::SUM_WIDTH-1:0]  diag_i,
  input  gmcp_pkg::cell_pos_t                    pos_i,
  output logic signed [gmcp_pkg::SUM_WIDTH-1:0]  sum_o,
  output logic                                   sat_o
);

  localparam int SW = gmcp_pkg::SUM_WIDTH;
  localparam int CW = gmcp_pkg::COST_WIDTH;

  logic signed [SW-1:0] min_ul;
  logic signed [SW-1:0] best;
  logic        [SW:0]   raw;

  always_comb begin
    min_ul = (left_i < up_i) ? left_i : up_i;
    if (pos_i.first_row) begin
      best = pos_i.first_col ? '0 : left_i;
    end else if (pos_i.first_col) begin
      best = up_i;
    end else begin
      best = (diag_i < min_ul) ? diag_i : min_ul;
    end
  end

  // One guard bit catches overflow of the signed sum.
  assign raw = {best[SW-1], best} + {{(SW + 1 - CW){cost_i[CW-1]}}, cost_i};

  always_comb begin
    sat_o = raw[SW] != raw[SW-1];
    if (!sat_o) begin
      sum_o = raw[SW-1:0];
    end else if (raw[SW]) begin
      sum_o = {1'b1, {(SW - 1){1'b0}}};
    end else begin
      sum_o = {1'b0, {(SW - 1){1'b1}}};
    end
  end

endmodule

>>> sv/grid_min_cost_path_top.sv
// The result is registered at the output as the last_cell item leaves the adder stage.
// Throughput: one cell per cycle unless the input is stalled; the row-store read is issued
//   at accept; the min-of-three add, saturation and write-back finish as the item retires.
// Input stalls only while a final cell in the adder stage waits on a full, stalled output.
// Reset (async, active low): origin position, first row, num_cols = 1; the row store
//   is not cleared, and values read from it are ignored in the first row.
module grid_min_cost_path_top #(
  parameter int MAX_COLS = gmcp_pkg::MAX_COLS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic [gmcp_pkg::NUM_COLS_WIDTH-1:0]        cfg_wdata_i,
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  gmcp_pkg::in_item_t                         in_data_i,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output gmcp_pkg::out_item_t                        out_data_o
);

  localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NCW = gmcp_pkg::NUM_COLS_WIDTH;
  localparam int WW  = (AW + 1 > NCW) ? AW + 1 : NCW;
  localparam int SW  = gmcp_pkg::SUM_WIDTH;

  // Item held in the adder stage while its row-store read completes.
  typedef struct packed {
    logic signed [gmcp_pkg::COST_WIDTH-1:0] cost;
    logic                                   last_cell;
    logic [AW-1:0]                          col;
    gmcp_pkg::cell_pos_t                    pos;
  } stage_t;

  // Configuration
  logic [NCW-1:0] num_cols_q;

  // Issue side: position of the next cell
  logic [AW-1:0]  col_pos_q, col_pos_d;
  logic           first_row_q, first_row_d;
  logic [WW-1:0]  width_eff;
  logic [WW-1:0]  col_next;
  logic           row_wrap;

  // Adder stage
  logic                  s1_valid_q, s1_valid_d;
  stage_t                s1_q;
  logic                  s1_fire;
  logic signed [SW-1:0]  left_sum_q, diag_sum_q;
  logic                  sat_seen_q;
  logic signed [SW-1:0]  ram_rdata, up_sum, new_sum;
  logic                  new_sat;

  // Forwarding of a write that lands on the entry read at the same edge
  logic                  fwd_valid_q;
  logic signed [SW-1:0]  fwd_data_q;

  // Output register
  logic                  out_valid_q;
  gmcp_pkg::out_item_t   out_data_q;

  logic                  in_fire;

  // Hold the input only when the adder stage has a final cell and the output
  // register is still full and stalled.
  assign in_stall_o = s1_valid_q && s1_q.last_cell && out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign s1_fire    = s1_valid_q && !in_stall_o;

  // Effective row width: zero acts as one, anything above the store depth is clipped.
  always_comb begin
    if (num_cols_q == '0) begin
      width_eff = WW'(1);
    end else if (WW'(num_cols_q) > WW'(MAX_COLS)) begin
      width_eff = WW'(MAX_COLS);
    end else begin
      width_eff = WW'(num_cols_q);
    end
    col_next = WW'(col_pos_q) + WW'(1);
    row_wrap = col_next >= width_eff;
  end

  // Advance the position; a final cell restarts the grid at the origin.
  always_comb begin
    col_pos_d   = col_pos_q;
    first_row_d = first_row_q;
    if (in_fire) begin
      if (in_data_i.last_cell) begin
        col_pos_d   = '0;
        first_row_d = 1'b1;
      end else if (row_wrap) begin
        col_pos_d   = '0;
        first_row_d = 1'b0;
      end else begin
        col_pos_d   = col_next[AW-1:0];
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q  <= NCW'(1);
      col_pos_q   <= '0;
      first_row_q <= 1'b1;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      left_sum_q  <= '0;
      diag_sum_q  <= '0;
      sat_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        num_cols_q <= cfg_wdata_i;
      end
      col_pos_q   <= col_pos_d;
      first_row_q <= first_row_d;
      s1_valid_q  <= s1_valid_d;
      // The RAM reads the old value when the write hits the same entry: flag it,
      // and hold the flag while the item waits in the adder stage.
      if (in_fire) begin
        fwd_valid_q <= s1_fire && (s1_q.col == col_pos_q);
      end else if (s1_fire) begin
        fwd_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        if (s1_q.last_cell) begin
          left_sum_q <= '0;
          diag_sum_q <= '0;
          sat_seen_q <= 1'b0;
        end else begin
          left_sum_q <= new_sum;
          if (!s1_q.pos.first_row) begin
            diag_sum_q <= up_sum;
          end
          sat_seen_q <= sat_seen_q || new_sat;
        end
      end
      if (s1_fire && s1_q.last_cell) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.cost          <= in_data_i.cell_cost;
      s1_q.last_cell     <= in_data_i.last_cell;
      s1_q.col           <= col_pos_q;
      s1_q.pos.first_row <= first_row_q;
      s1_q.pos.first_col <= col_pos_q == '0;
    end
    if (s1_fire) begin
      fwd_data_q <= new_sum;
    end
    if (s1_fire && s1_q.last_cell) begin
      out_data_q.path_cost <= new_sum;
      out_data_q.saturated <= sat_seen_q || new_sat;
    end
  end

  // Row store: read at accept, write back when the adder stage retires.
  gmcp_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_COLS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_q.col),
    .wdata_i (new_sum),
    .re_i    (in_fire),
    .raddr_i (col_pos_q),
    .rdata_o (ram_rdata)
  );

  assign up_sum = fwd_valid_q ? fwd_data_q : ram_rdata;

  gmcp_addsat u_addsat (
    .cost_i (s1_q.cost),
    .up_i   (up_sum),
    .left_i (left_sum_q),
    .diag_i (diag_sum_q),
    .pos_i  (s1_q.pos),
    .sum_o  (new_sum),
    .sat_o  (new_sat)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The input is held back only by a full, stalled output.
  a_stall_needs_full_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  // A forwarded value always belongs to an item sitting in the adder stage.
  a_fwd_has_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_valid_q |-> s1_valid_q)
    else $error("forwarding flag set without an item in the adder stage");

  // A final cell returns the issue side to the origin.
  a_restart_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.last_cell) |=> (col_pos_q == '0) && first_row_q)
    else $error("grid did not restart at origin after final cell");

  // A new result comes only from a final cell leaving the adder stage.
  a_result_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_fire && s1_q.last_cell))
    else $error("result produced without a final cell");

endmodule
